>>> rtl/core/sbch_pkg.sv
// ----------------------------------------------------------------------------
// SCSI bulk-only command handler package
// Shared types and constants for the command decoder and the handler core.
// ----------------------------------------------------------------------------
package sbch_pkg;

  // Command block wrapper signature ("USBC" in little-endian order).
  localparam logic [31:0] CBW_SIGNATURE = 32'h4342_5355;

  // SCSI operation codes handled by the block.
  localparam logic [7:0] OP_TEST_UNIT_READY  = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE    = 8'h03;
  localparam logic [7:0] OP_INQUIRY          = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE_6     = 8'h1A;
  localparam logic [7:0] OP_START_STOP_UNIT  = 8'h1B;
  localparam logic [7:0] OP_PREVENT_ALLOW    = 8'h1E;
  localparam logic [7:0] OP_READ_FORMAT_CAP  = 8'h23;
  localparam logic [7:0] OP_READ_CAPACITY_10 = 8'h25;
  localparam logic [7:0] OP_READ_10          = 8'h28;
  localparam logic [7:0] OP_WRITE_10         = 8'h2A;
  localparam logic [7:0] OP_VERIFY_10        = 8'h2F;

  // Response kinds.
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_SENSE      = 3'd1;
  localparam logic [2:0] KIND_INQUIRY    = 3'd2;
  localparam logic [2:0] KIND_MODE_SENSE = 3'd3;
  localparam logic [2:0] KIND_FORMAT_CAP = 3'd4;
  localparam logic [2:0] KIND_READ_CAP   = 3'd5;
  localparam logic [2:0] KIND_READ       = 3'd6;
  localparam logic [2:0] KIND_WRITE      = 3'd7;

  // Sense keys and additional sense codes.
  localparam logic [3:0] SK_NO_SENSE        = 4'h0;
  localparam logic [3:0] SK_NOT_READY       = 4'h2;
  localparam logic [3:0] SK_ILLEGAL_REQUEST = 4'h5;
  localparam logic [7:0] ASC_INVALID_OPCODE = 8'h20;
  localparam logic [7:0] ASC_NO_MEDIUM      = 8'h3A;

  // Reset value of the medium size register.
  localparam logic [31:0] DISK_BLOCKS_RESET = 32'hFFFF_FFFF;

  // One decoded command block wrapper.
  typedef struct packed {
    logic [15:0] transfer_length;
    logic [31:0] logical_block;
    logic [7:0]  start_stop_byte;
    logic [7:0]  scsi_opcode;
    logic [31:0] wrapper_tag;
    logic [31:0] wrapper_signature;
  } sbch_item_t;

  // One command result.
  typedef struct packed {
    logic        eject_request;
    logic        command_failed;
    logic [31:0] status_tag;
    logic [7:0]  reported_sense_code;
    logic [3:0]  reported_sense_key;
    logic [15:0] block_count;
    logic [31:0] first_block;
    logic [31:0] capacity_value;
    logic [2:0]  response_kind;
  } sbch_result_t;

  // Unit readiness and stored sense data.
  typedef struct packed {
    logic       unit_ready;
    logic [3:0] sense_key;
    logic [7:0] additional_sense;
  } sbch_state_t;

endpackage

>>> rtl/core/sbch_decode.sv
// ----------------------------------------------------------------------------
// SCSI command decoder
// Decodes one command against the readiness and sense state, giving the
// result and the next state in a single pass of logic.
// ----------------------------------------------------------------------------
module sbch_decode import sbch_pkg::*; (
  input  sbch_item_t   item,
  input  sbch_state_t  state,
  input  logic [31:0]  disk_blocks,
  output sbch_result_t result,
  output sbch_state_t  state_nxt
);

  logic [3:0] err_key;
  logic       err;

  always_comb begin
    result                     = '0;
    result.status_tag          = item.wrapper_tag;
    state_nxt                  = state;
    err                        = 1'b0;
    err_key                    = SK_NO_SENSE;

    // Opcode decode.
    unique case (item.scsi_opcode)
      OP_TEST_UNIT_READY: begin
        if (!state.unit_ready) begin
          err     = 1'b1;
          err_key = SK_NOT_READY;
        end
      end
      OP_REQUEST_SENSE: begin
        result.response_kind       = KIND_SENSE;
        result.reported_sense_key  = state.sense_key;
        result.reported_sense_code = state.additional_sense;
        state_nxt.sense_key        = state.unit_ready ? SK_NO_SENSE : SK_NOT_READY;
      end
      OP_INQUIRY: begin
        result.response_kind = KIND_INQUIRY;
      end
      OP_MODE_SENSE_6: begin
        result.response_kind = KIND_MODE_SENSE;
      end
      OP_START_STOP_UNIT: begin
        state_nxt.unit_ready = (item.start_stop_byte[7:1] == 7'd0);
        result.eject_request = (item.start_stop_byte[7:1] != 7'd0);
      end
      OP_PREVENT_ALLOW: begin
        err     = 1'b1;
        err_key = SK_ILLEGAL_REQUEST;
      end
      OP_READ_FORMAT_CAP: begin
        if (state.unit_ready) begin
          result.response_kind  = KIND_FORMAT_CAP;
          result.capacity_value = disk_blocks;
        end else begin
          err     = 1'b1;
          err_key = SK_NOT_READY;
        end
      end
      OP_READ_CAPACITY_10: begin
        // A failed read capacity leaves the sense data as it was.
        if (state.unit_ready) begin
          result.response_kind  = KIND_READ_CAP;
          result.capacity_value = disk_blocks - 32'd1;
        end else begin
          result.command_failed = 1'b1;
        end
      end
      OP_READ_10, OP_WRITE_10: begin
        if (state.unit_ready) begin
          result.response_kind = (item.scsi_opcode == OP_READ_10) ? KIND_READ : KIND_WRITE;
          result.first_block   = item.logical_block;
          result.block_count   = item.transfer_length;
        end else begin
          err     = 1'b1;
          err_key = SK_NOT_READY;
        end
      end
      OP_VERIFY_10: begin
      end
      default: begin
        err                        = 1'b1;
        err_key                    = SK_ILLEGAL_REQUEST;
        state_nxt.additional_sense = ASC_INVALID_OPCODE;
      end
    endcase

    // A command failed through err stores its sense key.
    if (err) begin
      result.command_failed = 1'b1;
      state_nxt.sense_key   = err_key;
    end
  end

endmodule

>>> rtl/core/scsi_bot_command_handler_core.sv
// ----------------------------------------------------------------------------
// SCSI bulk-only command handler core
// Checks command wrapper signatures, decodes SCSI opcodes against the unit
// readiness and sense state, and returns one result per valid wrapper.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one decoded command block wrapper per transfer.
//   A wrapper whose signature is wrong is consumed and gives no result.
//   Every other wrapper gives exactly one result transfer on the out_
//   channel, in order; the response kind travels on out_tuser.
//   The medium size is written through cfg_wr_en/cfg_wr_data; the user must
//   write it only while the block is idle, as the block does not enforce this.
// Timing:
//   An input register feeds the decoder, which feeds the result register.
//   A command passes through the input register and then the result register
//   before its result is offered on the out_ channel. One wrapper is accepted
//   every cycle while out_tready does not stall the result register; the rate
//   is set by the single decode pass between the two registers.
// Reset and stall:
//   Reset empties both registers, marks the unit ready with sense key
//   NOT READY / medium not present, and sets the medium size to all ones.
//   When out_tready is low the result holds and in_tready falls once the
//   input register holds a wrapper with a good signature; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module scsi_bot_command_handler_core import sbch_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: medium size in 512-byte blocks.
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  // Command input.
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] wrapper_signature, [63:32] wrapper_tag, [71:64] scsi_opcode,
  // [79:72] start_stop_byte, [111:80] logical_block, [127:112] transfer_length
  input  logic [127:0] in_tdata,
  // Result output.
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] capacity_value, [63:32] first_block, [79:64] block_count,
  // [83:80] reported_sense_key, [91:84] reported_sense_code,
  // [123:92] status_tag, [124] command_failed, [125] eject_request,
  // [127:126] zero
  output logic [127:0] out_tdata,
  // [2:0] response_kind
  output logic [2:0]   out_tuser
);

  logic         in_valid_r;
  sbch_item_t   in_item_r;
  sbch_state_t  state_r;
  sbch_state_t  state_nxt;
  logic [31:0]  disk_blocks_r;
  logic         out_valid_r;
  sbch_result_t out_result_r;
  sbch_result_t result;
  logic         sig_ok;
  logic         out_load;
  logic         stage_adv;

  // Pipeline flow control.
  assign sig_ok    = (in_item_r.wrapper_signature == CBW_SIGNATURE);
  assign out_load  = !out_valid_r || out_tready;
  assign stage_adv = in_valid_r && (!sig_ok || out_load);
  assign in_tready = !in_valid_r || stage_adv;

  // Medium size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_blocks_r <= DISK_BLOCKS_RESET;
    end else if (cfg_wr_en) begin
      disk_blocks_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= sbch_item_t'(in_tdata);
    end
  end

  // Command decode.
  sbch_decode u_decode (
    .item        (in_item_r),
    .state       (state_r),
    .disk_blocks (disk_blocks_r),
    .result      (result),
    .state_nxt   (state_nxt)
  );

  // Readiness and sense state, updated as each valid command leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.unit_ready       <= 1'b1;
      state_r.sense_key        <= SK_NOT_READY;
      state_r.additional_sense <= ASC_NO_MEDIUM;
    end else if (stage_adv && sig_ok) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r && sig_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid_r && sig_ok) begin
      out_result_r <= result;
    end
  end

  // Output packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_result_r.response_kind;
  assign out_tdata  = {2'b00,
                       out_result_r.eject_request,
                       out_result_r.command_failed,
                       out_result_r.status_tag,
                       out_result_r.reported_sense_code,
                       out_result_r.reported_sense_key,
                       out_result_r.block_count,
                       out_result_r.first_block,
                       out_result_r.capacity_value};

`ifndef ASSERT_OFF
  // The stored sense key only ever takes the values the decoder writes.
  a_sense_key_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.sense_key == SK_NO_SENSE) || (state_r.sense_key == SK_NOT_READY) ||
    (state_r.sense_key == SK_ILLEGAL_REQUEST))
    else $error("stored sense key out of range");

  // An eject comes only from a successful start/stop with no data response.
  a_eject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_r.eject_request |->
      !out_result_r.command_failed && (out_result_r.response_kind == KIND_NONE))
    else $error("eject request with failure or data response");

  // Sense data is reported only in a sense response.
  a_sense_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_result_r.response_kind != KIND_SENSE) |->
      (out_result_r.reported_sense_key == SK_NO_SENSE) &&
      (out_result_r.reported_sense_code == 8'd0))
    else $error("sense data outside a sense response");

  // A wrapper with a bad signature never loads the result register.
  a_bad_sig_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !sig_ok && !out_valid_r |=> !out_valid_r)
    else $error("bad signature produced a result");
`endif

endmodule

>>> verif/tb_scsi_bot_command_handler_core.sv
// ----------------------------------------------------------------------------
// Testbench for the SCSI bulk-only command handler core
// Drives command wrappers through a short table of directed cases and then
// several phases of random traffic with different idle and stall patterns.
// Every status transfer is compared field by field against its table entry or an
// in-bench decoder that tracks readiness, sense data and the medium size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scsi_bot_command_handler_core;
  import sbch_pkg::*;

  // Status wrapper signature; a command carrying it must be dropped.
  localparam logic [31:0] CSW_SIGNATURE = 32'h5342_5355;
  localparam int          PHASE_CMDS    = 150;
  localparam int          HOLD_CYCLES   = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // [31:0] wrapper_signature, [63:32] wrapper_tag, [71:64] scsi_opcode,
  // [79:72] start_stop_byte, [111:80] logical_block, [127:112] transfer_length
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] capacity_value, [63:32] first_block, [79:64] block_count,
  // [83:80] reported_sense_key, [91:84] reported_sense_code,
  // [123:92] status_tag, [124] command_failed, [125] eject_request
  logic [127:0] out_tdata;
  // [2:0] response_kind
  logic [2:0]   out_tuser;

  // One row of the directed table; a typed row carries its own status.
  typedef struct packed {
    logic         typed;
    sbch_result_t want;
    sbch_item_t   cmd;
  } cmd_row_t;

  sbch_state_t  unit_st;
  logic [31:0]  medium_blocks;
  sbch_result_t pending_status[$];
  cmd_row_t     cmd_table[$];

  event hold_go;
  logic hold_on = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cmds_sent = 0;
  int dropped_sent = 0;
  int status_seen = 0;
  int sizes_written = 0;
  int input_stalls = 0;

  scsi_bot_command_handler_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run hangs.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // Decode one wrapper against the tracked unit state. Returns 0 when the
  // wrapper is dropped, otherwise fills in the status it should produce.
  function automatic bit decode_command(input sbch_item_t c, output sbch_result_t r);
    logic [3:0] fail_key;
    r = '0;
    fail_key = SK_NO_SENSE;
    if (c.wrapper_signature != CBW_SIGNATURE) return 1'b0;
    r.status_tag = c.wrapper_tag;
    case (c.scsi_opcode)
      OP_TEST_UNIT_READY: begin
        if (!unit_st.unit_ready) fail_key = SK_NOT_READY;
      end
      OP_REQUEST_SENSE: begin
        r.response_kind       = KIND_SENSE;
        r.reported_sense_key  = unit_st.sense_key;
        r.reported_sense_code = unit_st.additional_sense;
        unit_st.sense_key     = unit_st.unit_ready ? SK_NO_SENSE : SK_NOT_READY;
      end
      OP_INQUIRY:      r.response_kind = KIND_INQUIRY;
      OP_MODE_SENSE_6: r.response_kind = KIND_MODE_SENSE;
      OP_START_STOP_UNIT: begin
        unit_st.unit_ready = (c.start_stop_byte[7:1] == 7'd0);
        r.eject_request    = !unit_st.unit_ready;
      end
      OP_PREVENT_ALLOW: fail_key = SK_ILLEGAL_REQUEST;
      OP_READ_FORMAT_CAP: begin
        if (unit_st.unit_ready) begin
          r.response_kind  = KIND_FORMAT_CAP;
          r.capacity_value = medium_blocks;
        end else begin
          fail_key = SK_NOT_READY;
        end
      end
      OP_READ_CAPACITY_10: begin
        // Not ready here fails but leaves the sense data alone.
        if (unit_st.unit_ready) begin
          r.response_kind  = KIND_READ_CAP;
          r.capacity_value = medium_blocks - 32'd1;
        end else begin
          r.command_failed = 1'b1;
        end
      end
      OP_READ_10, OP_WRITE_10: begin
        if (unit_st.unit_ready) begin
          r.response_kind = (c.scsi_opcode == OP_READ_10) ? KIND_READ : KIND_WRITE;
          r.first_block   = c.logical_block;
          r.block_count   = c.transfer_length;
        end else begin
          fail_key = SK_NOT_READY;
        end
      end
      OP_VERIFY_10: ;
      default: begin
        fail_key = SK_ILLEGAL_REQUEST;
        unit_st.additional_sense = ASC_INVALID_OPCODE;
      end
    endcase
    if (fail_key != SK_NO_SENSE) begin
      r.command_failed  = 1'b1;
      unit_st.sense_key = fail_key;
    end
    return 1'b1;
  endfunction

  function automatic sbch_item_t mk_cmd(input logic [31:0] sig, input logic [31:0] tag,
                                        input logic [7:0] op, input logic [7:0] ss,
                                        input logic [31:0] lba, input logic [15:0] len);
    sbch_item_t c;
    c.wrapper_signature = sig;
    c.wrapper_tag       = tag;
    c.scsi_opcode       = op;
    c.start_stop_byte   = ss;
    c.logical_block     = lba;
    c.transfer_length   = len;
    return c;
  endfunction

  function automatic sbch_result_t mk_status(input logic [2:0] kind, input logic [31:0] cap,
                                             input logic [31:0] first, input logic [15:0] cnt,
                                             input logic [3:0] key, input logic [7:0] code,
                                             input logic [31:0] tag, input logic failed,
                                             input logic eject);
    sbch_result_t r;
    r.response_kind       = kind;
    r.capacity_value      = cap;
    r.first_block         = first;
    r.block_count         = cnt;
    r.reported_sense_key  = key;
    r.reported_sense_code = code;
    r.status_tag          = tag;
    r.command_failed      = failed;
    r.eject_request       = eject;
    return r;
  endfunction

  task automatic add_row(input logic typed, input sbch_result_t want, input sbch_item_t cmd);
    cmd_table.push_back({typed, want, cmd});
  endtask

  // Random command: mostly well-formed wrappers with supported opcodes and
  // start/stop bytes that usually keep the unit ready; the rest is noise.
  function automatic sbch_item_t random_cmd();
    sbch_item_t c;
    int pick;
    c.wrapper_signature = CBW_SIGNATURE;
    c.wrapper_tag       = $urandom;
    c.start_stop_byte   = ($urandom_range(2) != 0) ? 8'($urandom_range(1)) : 8'($urandom);
    c.logical_block     = $urandom;
    c.transfer_length   = 16'($urandom);
    pick = $urandom_range(19);
    if (pick == 0) c.logical_block = '0;
    else if (pick == 1) c.logical_block = '1;
    else if (pick == 2) c.transfer_length = '0;
    else if (pick == 3) c.transfer_length = '1;
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(10))
        0:  c.scsi_opcode = OP_TEST_UNIT_READY;
        1:  c.scsi_opcode = OP_REQUEST_SENSE;
        2:  c.scsi_opcode = OP_INQUIRY;
        3:  c.scsi_opcode = OP_MODE_SENSE_6;
        4:  c.scsi_opcode = OP_START_STOP_UNIT;
        5:  c.scsi_opcode = OP_PREVENT_ALLOW;
        6:  c.scsi_opcode = OP_READ_FORMAT_CAP;
        7:  c.scsi_opcode = OP_READ_CAPACITY_10;
        8:  c.scsi_opcode = OP_READ_10;
        9:  c.scsi_opcode = OP_WRITE_10;
        default: c.scsi_opcode = OP_VERIFY_10;
      endcase
    end else begin
      c.scsi_opcode = 8'($urandom);
    end
    // A few broken wrappers: random, one bit off, or a status signature.
    pick = $urandom_range(99);
    if (pick < 3) c.wrapper_signature = $urandom;
    else if (pick < 6) c.wrapper_signature = CBW_SIGNATURE ^ (32'd1 << $urandom_range(31));
    else if (pick < 8) c.wrapper_signature = CSW_SIGNATURE;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ERROR at %0t ns: %s expected %h got %h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_status(input sbch_result_t want);
    if (out_tuser !== want.response_kind)
      report_mismatch("response_kind", 32'(want.response_kind), 32'(out_tuser));
    if (out_tdata[31:0] !== want.capacity_value)
      report_mismatch("capacity_value", want.capacity_value, out_tdata[31:0]);
    if (out_tdata[63:32] !== want.first_block)
      report_mismatch("first_block", want.first_block, out_tdata[63:32]);
    if (out_tdata[79:64] !== want.block_count)
      report_mismatch("block_count", 32'(want.block_count), 32'(out_tdata[79:64]));
    if (out_tdata[83:80] !== want.reported_sense_key)
      report_mismatch("reported_sense_key", 32'(want.reported_sense_key),
                      32'(out_tdata[83:80]));
    if (out_tdata[91:84] !== want.reported_sense_code)
      report_mismatch("reported_sense_code", 32'(want.reported_sense_code),
                      32'(out_tdata[91:84]));
    if (out_tdata[123:92] !== want.status_tag)
      report_mismatch("status_tag", want.status_tag, out_tdata[123:92]);
    if (out_tdata[124] !== want.command_failed)
      report_mismatch("command_failed", 32'(want.command_failed), 32'(out_tdata[124]));
    if (out_tdata[125] !== want.eject_request)
      report_mismatch("eject_request", 32'(want.eject_request), 32'(out_tdata[125]));
    if (out_tdata[127:126] !== 2'b00)
      report_mismatch("tdata padding", 32'd0, 32'(out_tdata[127:126]));
  endtask

  // Offer one command, starting at a falling edge, and record its status
  // once the transfer completes. Returns at the next falling edge.
  task automatic send_cmd(input sbch_item_t cmd, input logic typed, input sbch_result_t want);
    sbch_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (decode_command(cmd, pred)) begin
      pending_status.push_back(typed ? want : pred);
      cmds_sent++;
    end else begin
      dropped_sent++;
    end
    @(negedge clk);
  endtask

  // Write the medium size once every pending status has come back.
  task automatic write_disk(input logic [31:0] size);
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    medium_blocks = size;
    sizes_written++;
  endtask

  // Long receiver hold-off, counted in cycles once requested.
  always begin
    @(hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off while one is running.
  always @(negedge clk) begin
    if (hold_on) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Status checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected status, tag", 32'd0, out_tdata[123:92]);
      end else begin
        check_status(pending_status.pop_front());
        status_seen++;
      end
    end
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
  end

  initial begin : stimulus
    cmd_row_t   row;
    sbch_item_t cmd;
    int         ph;
    int         sent;

    unit_st.unit_ready       = 1'b1;
    unit_st.sense_key        = SK_NOT_READY;
    unit_st.additional_sense = ASC_NO_MEDIUM;
    medium_blocks            = DISK_BLOCKS_RESET;

    // Directed cases, starting from the reset state.
    add_row(1'b0, '0, mk_cmd(32'h0, 32'h0, 8'h00, 8'h00, 32'h0, 16'h0));
    add_row(1'b0, '0, mk_cmd('1, '1, 8'hFF, 8'hFF, '1, '1));
    add_row(1'b0, '0, mk_cmd(CSW_SIGNATURE, 32'h11, OP_INQUIRY, 8'h0, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_SENSE, '0, '0, '0, SK_NOT_READY, ASC_NO_MEDIUM, '1,
                            1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, '1, OP_REQUEST_SENSE, 8'h0, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_NONE, '0, '0, '0, '0, '0, 32'h0, 1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'h0, OP_TEST_UNIT_READY, 8'h0, 32'h0, 16'h0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'hA5A5_5A5A, OP_INQUIRY, 8'h0, '1, '1));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'h5A5A_A5A5, OP_MODE_SENSE_6, 8'hFF, '0, '0));
    add_row(1'b1, mk_status(KIND_FORMAT_CAP, '1, '0, '0, '0, '0, 32'd1, 1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd1, OP_READ_FORMAT_CAP, 8'h0, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_READ_CAP, 32'hFFFF_FFFE, '0, '0, '0, '0, 32'd2,
                            1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd2, OP_READ_CAPACITY_10, 8'h0, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_READ, '0, '1, '1, '0, '0, 32'd3, 1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd3, OP_READ_10, 8'h0, '1, '1));
    add_row(1'b1, mk_status(KIND_WRITE, '0, '0, '0, '0, '0, 32'd4, 1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd4, OP_WRITE_10, 8'h0, 32'h0, 16'h0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'h77, OP_VERIFY_10, 8'h0, 32'h1234, 16'h9));
    add_row(1'b1, mk_status(KIND_NONE, '0, '0, '0, '0, '0, 32'd5, 1'b1, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd5, OP_PREVENT_ALLOW, 8'h0, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_SENSE, '0, '0, '0, SK_ILLEGAL_REQUEST, ASC_NO_MEDIUM,
                            32'd6, 1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd6, OP_REQUEST_SENSE, 8'h0, 32'h0, 16'h0));
    // Unsupported opcode changes the additional sense code too.
    add_row(1'b1, mk_status(KIND_NONE, '0, '0, '0, '0, '0, 32'd7, 1'b1, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd7, 8'hFF, 8'h0, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_SENSE, '0, '0, '0, SK_ILLEGAL_REQUEST, ASC_INVALID_OPCODE,
                            32'd8, 1'b0, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd8, OP_REQUEST_SENSE, 8'h0, 32'h0, 16'h0));
    // Stop and eject, then every ready-dependent opcode while not ready.
    add_row(1'b1, mk_status(KIND_NONE, '0, '0, '0, '0, '0, 32'd9, 1'b0, 1'b1),
            mk_cmd(CBW_SIGNATURE, 32'd9, OP_START_STOP_UNIT, 8'hFF, 32'h0, 16'h0));
    add_row(1'b1, mk_status(KIND_NONE, '0, '0, '0, '0, '0, 32'd10, 1'b1, 1'b0),
            mk_cmd(CBW_SIGNATURE, 32'd10, OP_TEST_UNIT_READY, 8'h0, 32'h0, 16'h0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd11, OP_READ_FORMAT_CAP, 8'h0, '0, '0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd12, OP_READ_CAPACITY_10, 8'h0, '0, '0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd13, OP_READ_10, 8'h0, 32'h55, 16'h8));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd14, OP_WRITE_10, 8'h0, 32'hAA, 16'h10));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd15, OP_REQUEST_SENSE, 8'h0, '0, '0));
    // Only bits 7:1 of the start/stop byte decide readiness.
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd16, OP_START_STOP_UNIT, 8'h01, '0, '0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd17, OP_START_STOP_UNIT, 8'h02, '0, '0));
    add_row(1'b0, '0, mk_cmd(CBW_SIGNATURE, 32'd18, OP_START_STOP_UNIT, 8'h00, '0, '0));

    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 30;
    recv_stall_pct = 30;
    foreach (cmd_table[i]) begin
      row = cmd_table[i];
      send_cmd(row.cmd, row.typed, row.want);
    end
    in_tvalid <= 1'b0;

    // Random phases, each with its own medium size and idle pattern.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_disk(32'h0);  send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin write_disk(32'h1);  send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin write_disk($urandom); send_idle_pct = 0; recv_stall_pct = 63; end
        3: begin write_disk('1);     send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin
          // Long receiver hold-off while the sender keeps offering commands.
          write_disk($urandom);
          send_idle_pct  = 0;
          recv_stall_pct = 20;
          -> hold_go;
        end
      endcase
      sent = 0;
      while (sent < PHASE_CMDS) begin
        cmd = random_cmd();
        send_cmd(cmd, 1'b0, '0);
        if (cmd.wrapper_signature == CBW_SIGNATURE) sent++;
      end
      in_tvalid <= 1'b0;
    end

    // Drain, then leave room for anything stray.
    while (pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d accepted commands and %0d dropped wrappers over %0d medium sizes.",
             cmds_sent, dropped_sent, sizes_written);
    $display("Checked %0d status transfers; the input stalled for %0d cycles.",
             status_seen, input_stalls);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
